// ===== rtl/tccw_pkg.sv =====
// Shared types, constants and helpers for the text console cell writer.
`timescale 1ns / 1ps

package tccw_pkg;

  // Screen geometry
  localparam int COLS        = 32;
  localparam int ROWS        = 28;
  localparam int SCROLL_ROWS = 28;

  localparam int CELLS       = ROWS * COLS;
  localparam int REGION_ROWS = (SCROLL_ROWS < ROWS) ? SCROLL_ROWS : ROWS;
  localparam int COPY_CELLS  = (REGION_ROWS - 1) * COLS;
  localparam int CELL_AW     = $clog2(CELLS);
  localparam int CNT_W       = $clog2(CELLS + 1);
  localparam int POS_W       = 6;

  // Character codes and tiles
  localparam logic [7:0]  SPACE_CODE  = 8'h20;
  localparam logic [7:0]  QMARK_CODE  = 8'h3F;
  localparam logic [7:0]  NL_CODE     = 8'h0A;
  localparam logic [7:0]  BS_CODE     = 8'h08;
  localparam logic [7:0]  CR_CODE     = 8'h0D;
  localparam logic [7:0]  TOP_CODE    = 8'h80;
  localparam logic [15:0] RESET_BLANK = 16'h0020;

  // Operation codes
  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Configuration register indexes
  localparam int         CFG_IDX_W       = 1;
  localparam logic [0:0] REG_TEXT_BASE   = 1'b0;
  localparam logic [0:0] REG_CURSOR_TILE = 1'b1;

  // Follow-on step after an item has been decoded
  localparam logic [1:0] NEXT_DONE   = 2'd0;
  localparam logic [1:0] NEXT_READ   = 2'd1;
  localparam logic [1:0] NEXT_SCROLL = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [4:0]  col;
    logic [4:0]  row;
    logic [15:0] tile_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [4:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        refresh_request;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_en;
    logic latch_en;
    logic exec_en;
    logic rd_cap_en;
    logic scroll_en;
    logic blank_en;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] exec_next;
    logic       clear_last;
    logic       scroll_last;
    logic       blank_last;
  } dp_status_t;

  // Linear cell address of (row, col)
  function automatic logic [CNT_W-1:0] cell_addr(input logic [4:0] row,
                                                 input logic [4:0] col);
    return CNT_W'(CNT_W'(row) * CNT_W'(COLS) + CNT_W'(col));
  endfunction

endpackage

// ===== rtl/tccw_ctrl.sv =====
// Sequencing state machine for the text console cell writer.
`timescale 1ns / 1ps

module tccw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_valid,
  output tccw_pkg::dp_cmd_t    cmd,
  input  tccw_pkg::dp_status_t status
);
  import tccw_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RWAIT  = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_BLANK  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch_en = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec_en = 1'b1;
        unique case (status.exec_next)
          NEXT_READ:   state_nxt = S_RWAIT;
          NEXT_SCROLL: state_nxt = S_SCROLL;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_RWAIT: begin
        cmd.rd_cap_en = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SCROLL: begin
        cmd.scroll_en = 1'b1;
        if (status.scroll_last) state_nxt = S_BLANK;
      end
      S_BLANK: begin
        cmd.blank_en = 1'b1;
        if (status.blank_last) state_nxt = S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ===== rtl/tccw_datapath.sv =====
// Screen store, cursor, configuration registers and item decode.
`timescale 1ns / 1ps

module tccw_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tccw_pkg::in_item_t            in_item,
  input  logic                          cfg_valid,
  input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  input  tccw_pkg::dp_cmd_t             cmd,
  output tccw_pkg::dp_status_t          status,
  output tccw_pkg::out_item_t           out_item
);
  import tccw_pkg::*;

  logic [15:0] mem [0:CELLS-1];
  logic [15:0] mem_q_r;

  in_item_t    item_r;
  logic [15:0] base_r, ctile_r;
  logic [4:0]  cur_x_r, cur_x_nxt;
  logic [4:0]  cur_y_r, cur_y_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0] res_data_r, res_data_nxt;
  logic        refresh_r, refresh_nxt;

  logic             we;
  logic [CNT_W-1:0] waddr, raddr;
  logic [15:0]      wdata;

  logic [15:0]      blank_tile;
  logic [7:0]       put_code;
  logic [POS_W-1:0] x_inc, y_inc;
  logic             in_grid, cur_hit, do_newline, do_scroll;
  logic [1:0]       exec_next;

  assign blank_tile = base_r + 16'(SPACE_CODE);

  // Item decode
  always_comb begin
    put_code = item_r.char_code;
    if (item_r.char_code < SPACE_CODE || item_r.char_code >= TOP_CODE)
      put_code = QMARK_CODE;
  end

  assign x_inc   = {1'b0, cur_x_r} + POS_W'(1);
  assign y_inc   = {1'b0, cur_y_r} + POS_W'(1);
  assign in_grid = ({1'b0, item_r.col} < POS_W'(COLS)) &&
                   ({1'b0, item_r.row} < POS_W'(ROWS));
  assign cur_hit = (item_r.col == cur_x_r) && (item_r.row == cur_y_r);

  always_comb begin
    do_newline = 1'b0;
    if (item_r.operation == OP_PUT) begin
      priority if (item_r.char_code == CR_CODE) do_newline = 1'b0;
      else if (item_r.char_code == NL_CODE)     do_newline = 1'b1;
      else if (item_r.char_code == BS_CODE)     do_newline = 1'b0;
      else                                      do_newline = (x_inc >= POS_W'(COLS));
    end
  end

  assign do_scroll = do_newline && (y_inc >= POS_W'(REGION_ROWS));

  always_comb begin
    exec_next = NEXT_DONE;
    if (do_scroll)
      exec_next = NEXT_SCROLL;
    else if (item_r.operation == OP_READ && in_grid && !cur_hit)
      exec_next = NEXT_READ;
  end

  // Memory write port
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r;
    wdata = blank_tile;
    priority if (cmd.clear_en) begin
      we    = 1'b1;
      wdata = RESET_BLANK;
    end else if (cmd.exec_en) begin
      unique case (item_r.operation)
        OP_PUT: begin
          priority if (item_r.char_code == CR_CODE || item_r.char_code == NL_CODE) begin
            we = 1'b0;
          end else if (item_r.char_code == BS_CODE) begin
            we    = (cur_x_r != 5'd0);
            waddr = cell_addr(cur_y_r, cur_x_r - 5'd1);
          end else begin
            we    = 1'b1;
            waddr = cell_addr(cur_y_r, cur_x_r);
            wdata = base_r + 16'(put_code);
          end
        end
        OP_SET: begin
          we    = in_grid;
          waddr = cell_addr(item_r.row, item_r.col);
          wdata = item_r.tile_word;
        end
        default: we = 1'b0;
      endcase
    end else if (cmd.scroll_en) begin
      we    = (cnt_r != '0);
      waddr = cnt_r - CNT_W'(1);
      wdata = mem_q_r;
    end else if (cmd.blank_en) begin
      we    = 1'b1;
      waddr = cnt_r + CNT_W'(COPY_CELLS);
    end
  end

  // Memory read port
  always_comb begin
    raddr = cell_addr(item_r.row, item_r.col);
    if (cmd.scroll_en)
      raddr = (cnt_r < CNT_W'(COPY_CELLS)) ? cnt_r + CNT_W'(COLS) : '0;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr[CELL_AW-1:0]] <= wdata;
    mem_q_r <= mem[raddr[CELL_AW-1:0]];
  end

  // Step counter for clearing, scrolling and blanking
  always_comb begin
    cnt_nxt = cnt_r;
    priority if (cmd.clear_en || cmd.blank_en) cnt_nxt = cnt_r + CNT_W'(1);
    else if (cmd.exec_en)                       cnt_nxt = '0;
    else if (cmd.scroll_en)
      cnt_nxt = status.scroll_last ? '0 : cnt_r + CNT_W'(1);
  end

  assign status.exec_next   = exec_next;
  assign status.clear_last  = (cnt_r == CNT_W'(CELLS - 1));
  assign status.scroll_last = (cnt_r == CNT_W'(COPY_CELLS));
  assign status.blank_last  = (cnt_r == CNT_W'(COLS - 1));

  // Cursor and result update
  always_comb begin
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    res_data_nxt = res_data_r;
    refresh_nxt  = refresh_r;
    if (cmd.exec_en) begin
      res_data_nxt = '0;
      refresh_nxt  = do_newline;
      if (item_r.operation == OP_READ && in_grid && cur_hit) res_data_nxt = ctile_r;
      if (item_r.operation == OP_PUT) begin
        if (do_newline) begin
          cur_x_nxt = '0;
          cur_y_nxt = do_scroll ? 5'(REGION_ROWS - 1) : y_inc[4:0];
        end else if (item_r.char_code == BS_CODE) begin
          if (cur_x_r != 5'd0) cur_x_nxt = cur_x_r - 5'd1;
        end else if (item_r.char_code != CR_CODE) begin
          cur_x_nxt = x_inc[4:0];
        end
      end
    end else if (cmd.rd_cap_en) begin
      res_data_nxt = mem_q_r;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      refresh_r <= 1'b0;
      base_r    <= '0;
      ctile_r   <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      refresh_r <= refresh_nxt;
      if (cfg_valid && cfg_index == REG_TEXT_BASE)   base_r  <= cfg_data;
      if (cfg_valid && cfg_index == REG_CURSOR_TILE) ctile_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_en) item_r <= in_item;
    res_data_r <= res_data_nxt;
  end

  assign out_item.read_data       = res_data_r;
  assign out_item.cursor_col      = cur_x_r;
  assign out_item.cursor_row      = cur_y_r;
  assign out_item.refresh_request = refresh_r;

endmodule

// ===== rtl/text_console_cell_writer.sv =====
// An accepted item goes through EXEC to DONE, which gives the result beat; a read of
// a stored cell (in the grid, not under the cursor) also passes RWAIT. A newline that
// scrolls also runs the cell copy (SCROLL) and bottom-row blanking (BLANK),
// one cell a cycle. A new item is taken only in IDLE, after the previous result beat;
// results are never stalled. Reset (rst_n low, synchronous) clears cursor and
// registers, then busy stays high while the store is filled with blank tiles.
`timescale 1ns / 1ps

module text_console_cell_writer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  tccw_pkg::in_item_t             in_item,
  output logic                           out_valid,
  output tccw_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import tccw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration beats are always taken
  assign cfg_ready = 1'b1;

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  tccw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule

// ===== test/text_console_cell_writer_tb.sv =====
// Self-checking testbench for the text console cell writer: directed and random items.
`timescale 1ns / 1ps

module text_console_cell_writer_tb;
  import tccw_pkg::*;

  localparam int CYCLE_LIMIT   = 4000000;
  localparam int PHASE_ITEMS   = 137;
  localparam int REPORT_LIMIT  = 10;

  // Screen model plus the queue of results still to come
  class cell_writer_scoreboard;
    logic [15:0] cells [CELLS];
    int          cur_col;
    int          cur_row;
    logic [15:0] tile_base;
    logic [15:0] cursor_glyph;
    out_item_t   awaited_outputs [$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < CELLS; i++) cells[i] = RESET_BLANK;
      cur_col      = 0;
      cur_row      = 0;
      tile_base    = '0;
      cursor_glyph = '0;
      mismatches   = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      if (idx == REG_TEXT_BASE) tile_base = data;
      else if (idx == REG_CURSOR_TILE) cursor_glyph = data;
    endfunction

    function logic [15:0] glyph_of(logic [7:0] code);
      return tile_base + {8'h00, code};
    endfunction

    // Move every region row up by one, then blank the bottom region row
    function void shift_region_up();
      for (int i = 0; i < (REGION_ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
      for (int c = 0; c < COLS; c++) cells[(REGION_ROWS - 1) * COLS + c] = glyph_of(SPACE_CODE);
    endfunction

    function void line_feed();
      cur_col = 0;
      cur_row++;
      if (cur_row >= REGION_ROWS) begin
        shift_region_up();
        cur_row = REGION_ROWS - 1;
      end
    endfunction

    // Returns the refresh flag for one character
    function bit put_code(logic [7:0] code);
      logic [7:0] shown;
      shown = code;
      if (code == CR_CODE) return 1'b0;
      if (code == NL_CODE) begin
        line_feed();
        return 1'b1;
      end
      if (code == BS_CODE) begin
        if (cur_col > 0) begin
          cur_col--;
          cells[cur_row * COLS + cur_col] = glyph_of(SPACE_CODE);
        end
        return 1'b0;
      end
      if (code < SPACE_CODE || code >= TOP_CODE) shown = QMARK_CODE;
      cells[cur_row * COLS + cur_col] = glyph_of(shown);
      cur_col++;
      if (cur_col >= COLS) begin
        line_feed();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function out_item_t step_console(in_item_t it);
      out_item_t res;
      int        idx;
      res = '0;
      idx = int'(it.row) * COLS + int'(it.col);
      case (it.operation)
        OP_PUT: res.refresh_request = put_code(it.char_code);
        OP_SET: if (it.col < COLS && it.row < ROWS) cells[idx] = it.tile_word;
        OP_READ: begin
          if (it.col < COLS && it.row < ROWS) begin
            if (int'(it.col) == cur_col && int'(it.row) == cur_row) res.read_data = cursor_glyph;
            else res.read_data = cells[idx];
          end
        end
        default: ;
      endcase
      res.cursor_col = 5'(cur_col);
      res.cursor_row = 5'(cur_row);
      return res;
    endfunction

    function void note_item(in_item_t it);
      awaited_outputs.push_back(step_console(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: data %h col %0d row %0d refresh %0b",
                   got.read_data, got.cursor_col, got.cursor_row, got.refresh_request);
        return;
      end
      want = awaited_outputs.pop_front();
      if (got.read_data != want.read_data || got.cursor_col != want.cursor_col ||
          got.cursor_row != want.cursor_row || got.refresh_request != want.refresh_request) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"mismatch: expected data %h col %0d row %0d refresh %0b, ",
                    "got data %h col %0d row %0d refresh %0b"},
                   want.read_data, want.cursor_col, want.cursor_row, want.refresh_request,
                   got.read_data, got.cursor_col, got.cursor_row, got.refresh_request);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  cell_writer_scoreboard sb;
  int unsigned           cycle_count;

  text_console_cell_writer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL text_console_cell_writer");
      $finish;
    end
  end

  // Present one item and hold it until the block takes the beat
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Hold off until every outstanding result has arrived
  task automatic drain();
    idle_cycle();
    while (sb.awaited_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic [7:0] code, logic [4:0] c,
                                         logic [4:0] r, logic [15:0] tile);
    in_item_t it;
    it.operation = op;
    it.char_code = code;
    it.col       = c;
    it.row       = r;
    it.tile_word = tile;
    return it;
  endfunction

  // Mostly text with newlines, some edits, reads and raw writes
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it   = make_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     16'($urandom_range(0, 65535)));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.operation = OP_PUT;
      it.char_code = 8'($urandom_range(32'h20, 32'h7F));
    end else if (pick < 60) begin
      it.operation = OP_PUT;
      it.char_code = NL_CODE;
    end else if (pick < 64) begin
      it.operation = OP_PUT;
      it.char_code = BS_CODE;
    end else if (pick < 66) begin
      it.operation = OP_PUT;
      it.char_code = CR_CODE;
    end else if (pick < 70) begin
      it.operation = OP_PUT;
    end else if (pick < 80) begin
      it.operation = OP_SET;
      if ($urandom_range(0, 99) < 85) it.row = 5'($urandom_range(0, ROWS - 1));
    end else if (pick < 97) begin
      it.operation = OP_READ;
      if ($urandom_range(0, 99) < 35) begin
        it.col = 5'(sb.cur_col);
        it.row = 5'(sb.cur_row);
      end else if ($urandom_range(0, 99) < 90) begin
        it.row = 5'($urandom_range(0, ROWS - 1));
      end
    end else begin
      it.operation = 2'd3;
    end
    return it;
  endfunction

  initial begin
    int idle_pct;
    sb          = new();
    cycle_count = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    // wait out the clearing pass
    do @(posedge clk); while (busy);

    write_cfg(REG_TEXT_BASE, 16'hFFFF);
    write_cfg(REG_CURSOR_TILE, 16'h0000);

    // Directed: control codes, substitution, bounds, cursor overlay
    send_item(make_item(OP_READ, 8'h00, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, BS_CODE, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, 8'h41, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, 8'h00, 5'd31, 5'd31, 16'hFFFF));
    send_item(make_item(OP_PUT, 8'hFF, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, 8'h1F, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, 8'h80, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, 8'h7F, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, SPACE_CODE, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, CR_CODE, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, BS_CODE, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_READ, 8'h00, 5'd5, 5'd0, 16'h0000));
    send_item(make_item(OP_READ, 8'h00, 5'd6, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, NL_CODE, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_PUT, BS_CODE, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_SET, 8'h00, 5'd31, 5'd27, 16'hFFFF));
    send_item(make_item(OP_SET, 8'h00, 5'd0, 5'd28, 16'h1234));
    send_item(make_item(OP_SET, 8'h00, 5'd31, 5'd31, 16'hAAAA));
    send_item(make_item(OP_READ, 8'h00, 5'd31, 5'd27, 16'h0000));
    send_item(make_item(OP_READ, 8'h00, 5'd31, 5'd28, 16'h0000));
    send_item(make_item(OP_READ, 8'h00, 5'd0, 5'd31, 16'h0000));
    send_item(make_item(2'd3, 8'hFF, 5'd31, 5'd31, 16'hFFFF));
    send_item(make_item(OP_SET, 8'h00, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_READ, 8'h00, 5'd0, 5'd0, 16'h0000));
    send_item(make_item(OP_READ, 8'h00, 5'd1, 5'd0, 16'h0000));

    // Random phases, each with its own register setting and an idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          write_cfg(REG_TEXT_BASE, 16'h0000);
          write_cfg(REG_CURSOR_TILE, 16'hFFFF);
          idle_pct = 0;
        end
        1: begin
          write_cfg(REG_TEXT_BASE, 16'($urandom_range(0, 65535)));
          write_cfg(REG_CURSOR_TILE, 16'($urandom_range(0, 65535)));
          idle_pct = 57;
        end
        2: begin
          write_cfg(REG_TEXT_BASE, 16'h8000);
          write_cfg(REG_CURSOR_TILE, 16'h7FFF);
          idle_pct = 0;
        end
        default: begin
          write_cfg(REG_TEXT_BASE, 16'hFFE0);
          write_cfg(REG_CURSOR_TILE, 16'h5A5A);
          idle_pct = 13;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while ($urandom_range(0, 99) < idle_pct) idle_cycle();
        if ($urandom_range(0, 99) < 2 || (ph == 1 && n == 60)) drain();
        send_item(random_item());
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited_outputs.size() == 0) begin
      $display("PASS text_console_cell_writer");
    end else begin
      $display("FAIL text_console_cell_writer");
    end
    $finish;
  end

endmodule
